/* sv/pts_pkg.sv */
// Package for the priority task scheduler: sizes, request and result codes,
// controller state type and the command/status structs.
// No dependencies.
package pts_pkg;

    localparam int NUM_LEVELS = 3;
    localparam int MAX_PROCS  = 16;
    localparam int LVL_W      = 2;
    localparam int PTR_W      = 4;
    localparam int CNT_W      = 5;
    localparam int Q_DEPTH    = NUM_LEVELS * MAX_PROCS;
    localparam int QA_W       = LVL_W + PTR_W;
    localparam int DIV_STEPS  = 64;
    localparam int DCNT_W     = 6;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [31:0] TICK_RATE_RESET = 32'd10000000;

    // request codes
    localparam logic [2:0] REQ_RESUME = 3'd0;
    localparam logic [2:0] REQ_RUN    = 3'd1;
    localparam logic [2:0] REQ_YIELD  = 3'd2;
    localparam logic [2:0] REQ_SLEEP  = 3'd3;
    localparam logic [2:0] REQ_BLOCK  = 3'd4;

    // result codes
    localparam logic [1:0] RC_DONE  = 2'd0;
    localparam logic [1:0] RC_FULL  = 2'd1;
    localparam logic [1:0] RC_PAST  = 2'd2;

    // process status
    localparam logic [1:0] PS_WAITING  = 2'd0;
    localparam logic [1:0] PS_RUNNING  = 2'd1;
    localparam logic [1:0] PS_SLEEPING = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_DIVI, S_DIV, S_EXEC, S_YIELD,
        S_WLVL, S_WRD, S_WEV, S_PICK, S_POP, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_MUL0, OP_MUL1, OP_DIVI, OP_DIV, OP_EXEC, OP_YIELD,
        OP_WLVL, OP_WRD, OP_WEV, OP_PICK, OP_POP, OP_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic exec_yield;
        logic exec_block;
        logic yield_ok;
        logic lvl_has;
        logic last_lvl;
        logic more;
        logic any_ready;
    } stat_t;

endpackage

/* sv/pts_ctrl.sv */
// Controller state machine of the scheduler: sequences multiply, divide,
// request execution, sleeper wake sweep and ready pick.
// Depends on pts_pkg.
module pts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pts_pkg::stat_t st,
    output pts_pkg::cmd_t cmd,
    output logic          busy,
    output logic          result_valid
);
    import pts_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_MUL0;
            S_MUL0:  state_next = S_MUL1;
            S_MUL1:  state_next = S_DIVI;
            S_DIVI:  state_next = S_DIV;
            S_DIV:   if (st.div_last) state_next = S_EXEC;
            S_EXEC:
            begin
                if (st.exec_yield)      state_next = S_YIELD;
                else if (st.exec_block) state_next = S_WLVL;
                else                    state_next = S_DONE;
            end
            S_YIELD: state_next = st.yield_ok ? S_WLVL : S_DONE;
            S_WLVL:
            begin
                if (st.lvl_has)       state_next = S_WRD;
                else if (st.last_lvl) state_next = S_PICK;
                else                  state_next = S_WLVL;
            end
            S_WRD:   state_next = S_WEV;
            S_WEV:
            begin
                if (st.more)          state_next = S_WRD;
                else if (st.last_lvl) state_next = S_PICK;
                else                  state_next = S_WLVL;
            end
            S_PICK:  state_next = st.any_ready ? S_POP : S_DONE;
            S_POP:   state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op       = OP_NONE;
        busy         = (state_reg != S_IDLE);
        result_valid = (state_reg == S_DONE);
        case (state_reg)
            S_IDLE:  cmd.op = start ? OP_LATCH : OP_NONE;
            S_MUL0:  cmd.op = OP_MUL0;
            S_MUL1:  cmd.op = OP_MUL1;
            S_DIVI:  cmd.op = OP_DIVI;
            S_DIV:   cmd.op = OP_DIV;
            S_EXEC:  cmd.op = OP_EXEC;
            S_YIELD: cmd.op = OP_YIELD;
            S_WLVL:  cmd.op = OP_WLVL;
            S_WRD:   cmd.op = OP_WRD;
            S_WEV:   cmd.op = OP_WEV;
            S_PICK:  cmd.op = OP_PICK;
            S_POP:   cmd.op = OP_POP;
            S_DONE:  cmd.op = OP_DONE;
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

/* sv/pts_dp.sv */
// Datapath of the scheduler: time conversion (split multiply, restoring
// divider), ring-buffer ready/sleep queues in memories, per-process state.
// Depends on pts_pkg.
module pts_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  pts_pkg::cmd_t cmd,
    output pts_pkg::stat_t st,
    input  logic [2:0]    req_type,
    input  logic [3:0]    proc_id,
    input  logic [63:0]   wake_deadline_ns,
    input  logic [63:0]   now_ticks,
    input  logic [7:0]    program_index,
    input  logic          cfg_valid,
    input  logic [31:0]   cfg_tick_rate_hz,
    output logic          switched,
    output logic [3:0]    prev_proc,
    output logic [3:0]    next_proc,
    output logic [4:0]    woken_count,
    output logic [1:0]    result_code
);
    import pts_pkg::*;

    // queue memories
    logic [PTR_W-1:0] ready_mem [0:Q_DEPTH-1];
    logic [PTR_W-1:0] sleep_mem [0:Q_DEPTH-1];
    logic             rwe, swe;
    logic [QA_W-1:0]  rwa, swa, rra, sra;
    logic [PTR_W-1:0] rwd, swd;
    logic [PTR_W-1:0] rrd_reg, srd_reg;

    // control and bookkeeping
    logic [31:0]        rate_reg, rate_next;
    logic [2:0]         req_reg, req_next;
    logic [PTR_W-1:0]   pid_reg, pid_next;
    logic [63:0]        dl_reg, dl_next;
    logic [63:0]        ticks_reg, ticks_next;
    logic [7:0]         prog_reg, prog_next;
    logic [63:0]        p0_reg, p0_next;
    logic [31:0]        p1_reg, p1_next;
    logic [63:0]        quo_reg, quo_next;
    logic [31:0]        rem_reg, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [PTR_W-1:0]   cur_reg, cur_next;
    logic [PTR_W-1:0]   prev_reg, prev_next;
    logic [PTR_W-1:0]   old_reg, old_next;
    logic               sw_reg, sw_next;
    logic [CNT_W-1:0]   woken_reg, woken_next;
    logic [1:0]         code_reg, code_next;
    logic [LVL_W-1:0]   wlvl_reg, wlvl_next;
    logic [CNT_W-1:0]   wrem_reg, wrem_next;
    logic [LVL_W-1:0]   plvl_reg, plvl_next;

    logic [CNT_W-1:0]   rcnt_reg [NUM_LEVELS], rcnt_next [NUM_LEVELS];
    logic [PTR_W-1:0]   rhead_reg [NUM_LEVELS], rhead_next [NUM_LEVELS];
    logic [CNT_W-1:0]   scnt_reg [NUM_LEVELS], scnt_next [NUM_LEVELS];
    logic [PTR_W-1:0]   shead_reg [NUM_LEVELS], shead_next [NUM_LEVELS];

    logic [1:0]         pstat_reg [MAX_PROCS], pstat_next [MAX_PROCS];
    logic [63:0]        pdl_reg [MAX_PROCS], pdl_next [MAX_PROCS];
    logic               pmay_reg [MAX_PROCS], pmay_next [MAX_PROCS];

    // combinational helpers
    logic [31:0]      divisor;
    logic [32:0]      rshift, rdiff;
    logic             past;
    logic [LVL_W-1:0] pick_lvl;
    logic             any_ready;
    logic             due;
    logic             yield_ok;
    logic             full_r0, full_r1, full_s1;

    assign divisor = (rate_reg == 32'd0) ? 32'd1 : rate_reg;
    assign rshift  = {rem_reg, quo_reg[63]};
    assign rdiff   = rshift - {1'b0, divisor};
    assign past    = (dl_reg <= quo_reg);
    assign due     = (quo_reg >= pdl_reg[srd_reg]);
    assign full_r0 = (rcnt_reg[0] == CNT_W'(MAX_PROCS));
    assign full_r1 = (rcnt_reg[1] == CNT_W'(MAX_PROCS));
    assign full_s1 = (scnt_reg[1] == CNT_W'(MAX_PROCS));
    assign yield_ok = pmay_reg[cur_reg] &&
                      ((pstat_reg[cur_reg] == PS_SLEEPING) ? !full_s1 : !full_r1);

    // lowest-numbered non-empty ready level
    always_comb
    begin
        pick_lvl  = '0;
        any_ready = 1'b0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (rcnt_reg[l] != '0)
            begin
                pick_lvl  = LVL_W'(l);
                any_ready = 1'b1;
            end
        end
    end

    // status to controller
    always_comb
    begin
        st.div_last   = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
        st.exec_yield = (req_reg == REQ_YIELD) ||
                        ((req_reg == REQ_SLEEP) && !past && (cur_reg == pid_reg));
        st.exec_block = (req_reg == REQ_BLOCK);
        st.yield_ok   = yield_ok;
        st.lvl_has    = (scnt_reg[wlvl_reg] != '0);
        st.last_lvl   = (wlvl_reg == LVL_W'(NUM_LEVELS - 1));
        st.more       = (wrem_reg > CNT_W'(1));
        st.any_ready  = any_ready;
    end

    // next-state logic
    always_comb
    begin
        rate_next  = rate_reg;
        req_next   = req_reg;
        pid_next   = pid_reg;
        dl_next    = dl_reg;
        ticks_next = ticks_reg;
        prog_next  = prog_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        old_next   = old_reg;
        sw_next    = sw_reg;
        woken_next = woken_reg;
        code_next  = code_reg;
        wlvl_next  = wlvl_reg;
        wrem_next  = wrem_reg;
        plvl_next  = plvl_reg;
        rcnt_next  = rcnt_reg;
        rhead_next = rhead_reg;
        scnt_next  = scnt_reg;
        shead_next = shead_reg;
        pstat_next = pstat_reg;
        pdl_next   = pdl_reg;
        pmay_next  = pmay_reg;
        rwe = 1'b0;
        swe = 1'b0;
        rwa = '0;
        swa = '0;
        rwd = '0;
        swd = '0;
        rra = {pick_lvl, rhead_reg[pick_lvl]};
        sra = {wlvl_reg, shead_reg[wlvl_reg]};

        if (cfg_valid)
        begin
            rate_next = cfg_tick_rate_hz;
        end

        case (cmd.op)
            OP_LATCH:
            begin
                req_next   = req_type;
                pid_next   = proc_id;
                dl_next    = wake_deadline_ns;
                ticks_next = now_ticks;
                prog_next  = program_index;
                prev_next  = cur_reg;
                sw_next    = 1'b0;
                woken_next = '0;
                code_next  = RC_DONE;
                wlvl_next  = '0;
            end
            OP_MUL0: p0_next = 64'(ticks_reg[31:0] * NS_PER_SEC);
            OP_MUL1: p1_next = 32'(ticks_reg[63:32] * NS_PER_SEC);
            OP_DIVI:
            begin
                quo_next  = p0_reg + {p1_reg, 32'd0};
                rem_next  = '0;
                dcnt_next = '0;
            end
            OP_DIV:
            begin
                if (!rdiff[32])
                begin
                    rem_next = rdiff[31:0];
                end
                else
                begin
                    rem_next = rshift[31:0];
                end
                quo_next  = {quo_reg[62:0], !rdiff[32]};
                dcnt_next = dcnt_reg + DCNT_W'(1);
            end
            OP_EXEC:
            begin
                case (req_reg)
                    REQ_RESUME:
                    begin
                        if (full_r0)
                        begin
                            code_next = RC_FULL;
                        end
                        else
                        begin
                            rwe = 1'b1;
                            rwa = {LVL_W'(0), PTR_W'(rhead_reg[0] + rcnt_reg[0][PTR_W-1:0])};
                            rwd = pid_reg;
                            rcnt_next[0] = rcnt_reg[0] + CNT_W'(1);
                        end
                    end
                    REQ_RUN:
                    begin
                        if (full_r0)
                        begin
                            code_next = RC_FULL;
                        end
                        else
                        begin
                            rwe = 1'b1;
                            rwa = {LVL_W'(0), PTR_W'(rhead_reg[0] + rcnt_reg[0][PTR_W-1:0])};
                            rwd = cur_reg;
                            rcnt_next[0] = rcnt_reg[0] + CNT_W'(1);
                            pstat_next[pid_reg] = PS_RUNNING;
                            pdl_next[pid_reg]   = '0;
                            pmay_next[pid_reg]  = (prog_reg != '0);
                            cur_next = pid_reg;
                            sw_next  = (pid_reg != cur_reg);
                        end
                    end
                    REQ_SLEEP:
                    begin
                        if (past)
                        begin
                            code_next = RC_PAST;
                        end
                        else
                        begin
                            pstat_next[pid_reg] = PS_SLEEPING;
                            pdl_next[pid_reg]   = dl_reg;
                        end
                    end
                    REQ_BLOCK: old_next = pid_reg;
                    default: ;
                endcase
            end
            OP_YIELD:
            begin
                if (pmay_reg[cur_reg])
                begin
                    if (!yield_ok)
                    begin
                        code_next = RC_FULL;
                    end
                    else if (pstat_reg[cur_reg] == PS_SLEEPING)
                    begin
                        swe = 1'b1;
                        swa = {LVL_W'(1), PTR_W'(shead_reg[1] + scnt_reg[1][PTR_W-1:0])};
                        swd = cur_reg;
                        scnt_next[1] = scnt_reg[1] + CNT_W'(1);
                    end
                    else
                    begin
                        rwe = 1'b1;
                        rwa = {LVL_W'(1), PTR_W'(rhead_reg[1] + rcnt_reg[1][PTR_W-1:0])};
                        rwd = cur_reg;
                        rcnt_next[1] = rcnt_reg[1] + CNT_W'(1);
                    end
                    old_next = cur_reg;
                end
            end
            OP_WLVL:
            begin
                if (scnt_reg[wlvl_reg] == '0)
                begin
                    wlvl_next = wlvl_reg + LVL_W'(1);
                end
                else
                begin
                    wrem_next = scnt_reg[wlvl_reg];
                end
            end
            OP_WEV:
            begin
                shead_next[wlvl_reg] = shead_reg[wlvl_reg] + PTR_W'(1);
                if (due && (rcnt_reg[wlvl_reg] != CNT_W'(MAX_PROCS)))
                begin
                    // move sleeper to the ready queue of its level
                    rwe = 1'b1;
                    rwa = {wlvl_reg,
                           PTR_W'(rhead_reg[wlvl_reg] + rcnt_reg[wlvl_reg][PTR_W-1:0])};
                    rwd = srd_reg;
                    rcnt_next[wlvl_reg] = rcnt_reg[wlvl_reg] + CNT_W'(1);
                    scnt_next[wlvl_reg] = scnt_reg[wlvl_reg] - CNT_W'(1);
                    pstat_next[srd_reg] = PS_WAITING;
                    pdl_next[srd_reg]   = '0;
                    woken_next = woken_reg + CNT_W'(1);
                end
                else
                begin
                    // keep: back to the tail of the same sleep queue
                    if (due)
                    begin
                        code_next = RC_FULL;
                    end
                    swe = 1'b1;
                    swa = {wlvl_reg,
                           PTR_W'(shead_reg[wlvl_reg] + scnt_reg[wlvl_reg][PTR_W-1:0])};
                    swd = srd_reg;
                end
                wrem_next = wrem_reg - CNT_W'(1);
                if (wrem_reg == CNT_W'(1))
                begin
                    wlvl_next = wlvl_reg + LVL_W'(1);
                end
            end
            OP_PICK: plvl_next = pick_lvl;
            OP_POP:
            begin
                rhead_next[plvl_reg] = rhead_reg[plvl_reg] + PTR_W'(1);
                rcnt_next[plvl_reg]  = rcnt_reg[plvl_reg] - CNT_W'(1);
                if (rrd_reg != old_reg)
                begin
                    if (pstat_reg[old_reg] == PS_RUNNING)
                    begin
                        pstat_next[old_reg] = PS_WAITING;
                    end
                    pstat_next[rrd_reg] = PS_RUNNING;
                    pdl_next[rrd_reg]   = '0;
                    cur_next = rrd_reg;
                    sw_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= TICK_RATE_RESET;
            dcnt_reg  <= '0;
            cur_reg   <= '0;
            wlvl_reg  <= '0;
            wrem_reg  <= '0;
            plvl_reg  <= '0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                rcnt_reg[l]  <= '0;
                rhead_reg[l] <= '0;
                scnt_reg[l]  <= '0;
                shead_reg[l] <= '0;
            end
            for (int p = 0; p < MAX_PROCS; p++)
            begin
                pstat_reg[p] <= PS_WAITING;
                pdl_reg[p]   <= '0;
                pmay_reg[p]  <= 1'b0;
            end
        end
        else
        begin
            rate_reg   <= rate_next;
            dcnt_reg   <= dcnt_next;
            cur_reg    <= cur_next;
            wlvl_reg   <= wlvl_next;
            wrem_reg   <= wrem_next;
            plvl_reg   <= plvl_next;
            rcnt_reg   <= rcnt_next;
            rhead_reg  <= rhead_next;
            scnt_reg   <= scnt_next;
            shead_reg  <= shead_next;
            pstat_reg  <= pstat_next;
            pdl_reg    <= pdl_next;
            pmay_reg   <= pmay_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        pid_reg    <= pid_next;
        dl_reg     <= dl_next;
        ticks_reg  <= ticks_next;
        prog_reg   <= prog_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        prev_reg   <= prev_next;
        old_reg    <= old_next;
        sw_reg     <= sw_next;
        woken_reg  <= woken_next;
        code_reg   <= code_next;
    end

    // ready queue memory
    always_ff @(posedge clk)
    begin
        if (rwe)
        begin
            ready_mem[rwa] <= rwd;
        end
        rrd_reg <= ready_mem[rra];
    end

    // sleep queue memory
    always_ff @(posedge clk)
    begin
        if (swe)
        begin
            sleep_mem[swa] <= swd;
        end
        srd_reg <= sleep_mem[sra];
    end

    assign switched    = sw_reg;
    assign prev_proc   = prev_reg;
    assign next_proc   = cur_reg;
    assign woken_count = woken_reg;
    assign result_code = code_reg;

endmodule

/* sv/priority_task_scheduler_core.sv */
// Top level of the priority task scheduler: controller plus datapath.
// Depends on pts_pkg, pts_ctrl, pts_dp.
//
// channel   | handshake                  | payload
// request   | start in, busy out         | req_type, proc_id, wake_deadline_ns,
//           |                            | now_ticks, program_index
// result    | result_valid out (1 cycle) | switched, prev_proc, next_proc,
//           |                            | woken_count, result_code
// config    | cfg_valid in, cfg_ready out| cfg_tick_rate_hz
//
// A request runs the split multiply, then the bit-serial 64/32 divider, then
// the request itself. A yield (or a sleep of the running process) enqueues the
// current process; a block or an accepted yield then sweeps each sleep level,
// reading every queued sleeper from the registered sleep memory, and ends with
// the ready pick. Only sleep level 1 is ever filled (16 deep).
// Async reset, queues come up empty with no clearing pass; the result is held
// one cycle only (no receiver stall); config writes are taken only while idle.
module priority_task_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [3:0]  proc_id,
    input  logic [63:0] wake_deadline_ns,
    input  logic [63:0] now_ticks,
    input  logic [7:0]  program_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_tick_rate_hz,
    output logic        result_valid,
    output logic        switched,
    output logic [3:0]  prev_proc,
    output logic [3:0]  next_proc,
    output logic [4:0]  woken_count,
    output logic [1:0]  result_code
);
    import pts_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  cfg_we;

    // tick rate may only change between requests
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    pts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .st           (st),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    pts_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .req_type         (req_type),
        .proc_id          (proc_id),
        .wake_deadline_ns (wake_deadline_ns),
        .now_ticks        (now_ticks),
        .program_index    (program_index),
        .cfg_valid        (cfg_we),
        .cfg_tick_rate_hz (cfg_tick_rate_hz),
        .switched         (switched),
        .prev_proc        (prev_proc),
        .next_proc        (next_proc),
        .woken_count      (woken_count),
        .result_code      (result_code)
    );

endmodule
